>>> rtl/scb_pkg.sv
`timescale 1ns / 1ps
package scb_pkg;

    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_DD    = 2;
    localparam int SQRT_N   = 28;
    localparam int ST_SQRT0 = 3;
    localparam int DIV_N    = 17;
    localparam int ST_DIV0  = ST_SQRT0 + SQRT_N;
    localparam int ST_NRM   = ST_DIV0 + DIV_N;
    localparam int ST_PRD   = ST_NRM + 1;
    localparam int ST_DOT   = ST_PRD + 1;
    localparam int ST_REF   = ST_DOT + 1;
    localparam int ST_BNC   = ST_REF + 1;
    localparam int ST_NEW   = ST_BNC + 1;
    localparam int N_STAGES = ST_NEW + 1;

    localparam logic [16:0] N_ONE = 17'd65536;

    typedef struct packed {
        logic [2:0][23:0] vel;
        logic [2:0][23:0] oth;
        logic [2:0][24:0] d;
        logic [2:0][48:0] sq;
        logic [20:0]      rs;
        logic [41:0]      rs2;
        logic             hit;
        logic             dz;
        logic [55:0]      sx;
        logic [56:0]      sr;
        logic [2:0][47:0] rem;
        logic [2:0][16:0] quo;
        logic [2:0]       neg;
        logic [2:0][17:0] nrm;
        logic [2:0][41:0] prd;
        logic [43:0]      dot;
        logic [2:0][61:0] tp;
        logic [2:0][23:0] bnc;
        logic [2:0][23:0] nw;
    } t_pl;

    function automatic logic [23:0] f_sat24(input logic signed [33:0] v);
        logic [23:0] res;
        if (v > 34'sd8388607) begin
            res = 24'h7FFFFF;
        end else if (v < -34'sd8388608) begin
            res = 24'h800000;
        end else begin
            res = v[23:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/sphere_collision_bounce.sv
`timescale 1ns / 1ps
// Throughput: one sphere pair per cycle while the output does not stall, set by a
// 54-stage pipeline in which the square root takes one result bit per stage and each
// normal division one quotient bit.
// Every stage holds its own valid bit, so bubbles close up while the output stalls.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module sphere_collision_bounce import scb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // own_x, own_y, own_z, own_radius, other_x, other_y, other_z, other_radius,
    // vel_x, vel_y, vel_z
    input  logic [255:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // bounce_x, bounce_y, bounce_z, new_x, new_y, new_z
    output logic [143:0] o_m_tdata,
    // hit
    output logic         o_m_tuser
);

    t_pl  r_pl [N_STAGES];
    t_pl  n_pl [N_STAGES];
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] en;

    assign en[N_STAGES-1] = !r_v[N_STAGES-1] || i_m_tready;

    for (genvar k = 0; k < N_STAGES - 1; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    assign o_s_tready = en[0];

    for (genvar k = 0; k < N_STAGES; k++) begin : g_st
        if (k == ST_IN) begin : g_in
            always_comb begin
                n_pl[k] = '0;
                for (int i = 0; i < 3; i++) begin
                    n_pl[k].vel[i] = i_s_tdata[184 + 24*i +: 24];
                    n_pl[k].oth[i] = i_s_tdata[92 + 24*i +: 24];
                    n_pl[k].d[i]   = 25'($signed(i_s_tdata[24*i +: 24])
                                     - $signed(i_s_tdata[92 + 24*i +: 24]));
                end
                n_pl[k].rs = {1'b0, i_s_tdata[91:72]} + {1'b0, i_s_tdata[183:164]};
            end
        end else begin : g_wk
            always_comb begin
                logic [50:0] dd;
                logic [56:0] rb;
                logic [47:0] dv;
                logic [24:0] ad;
                logic signed [17:0] nv;
                logic signed [62:0] rq;
                logic signed [33:0] q;
                n_pl[k] = r_pl[k-1];
                dd = '0;
                rb = '0;
                dv = '0;
                ad = '0;
                nv = '0;
                rq = '0;
                q  = '0;
                if (k == ST_SQ) begin
                    for (int i = 0; i < 3; i++) begin
                        n_pl[k].sq[i] = 49'($signed(r_pl[k-1].d[i])
                                        * $signed(r_pl[k-1].d[i]));
                    end
                    n_pl[k].rs2 = r_pl[k-1].rs * r_pl[k-1].rs;
                end else if (k == ST_DD) begin
                    dd = 51'(r_pl[k-1].sq[0]) + 51'(r_pl[k-1].sq[1])
                       + 51'(r_pl[k-1].sq[2]);
                    n_pl[k].hit = 51'(r_pl[k-1].rs2) > dd;
                    n_pl[k].dz  = dd == '0;
                    n_pl[k].sx  = {dd[41:0], 14'b0};
                    n_pl[k].sr  = '0;
                    for (int i = 0; i < 3; i++) begin
                        n_pl[k].neg[i] = r_pl[k-1].d[i][24];
                        ad = r_pl[k-1].d[i][24] ? 25'(-r_pl[k-1].d[i]) : r_pl[k-1].d[i];
                        n_pl[k].rem[i] = {ad, 23'b0};
                        n_pl[k].quo[i] = '0;
                    end
                end else if (k >= ST_SQRT0 && k < ST_DIV0) begin
                    // One result bit of the integer square root per stage.
                    rb = r_pl[k-1].sr + (57'(1) << (54 - 2*(k - ST_SQRT0)));
                    if (57'(r_pl[k-1].sx) >= rb) begin
                        n_pl[k].sx = r_pl[k-1].sx - rb[55:0];
                        n_pl[k].sr = (r_pl[k-1].sr >> 1)
                                   + (57'(1) << (54 - 2*(k - ST_SQRT0)));
                    end else begin
                        n_pl[k].sr = r_pl[k-1].sr >> 1;
                    end
                end else if (k >= ST_DIV0 && k < ST_NRM) begin
                    // Restoring division, quotient bits from the top down.
                    dv = 48'(r_pl[k-1].sr[27:0]) << (DIV_N - 1 - (k - ST_DIV0));
                    for (int i = 0; i < 3; i++) begin
                        if (r_pl[k-1].rem[i] >= dv) begin
                            n_pl[k].rem[i] = r_pl[k-1].rem[i] - dv;
                            n_pl[k].quo[i][DIV_N - 1 - (k - ST_DIV0)] = 1'b1;
                        end
                    end
                end else if (k == ST_NRM) begin
                    for (int i = 0; i < 3; i++) begin
                        nv = (r_pl[k-1].quo[i] > N_ONE) ? 18'(N_ONE)
                                                         : 18'(r_pl[k-1].quo[i]);
                        if (r_pl[k-1].dz) begin
                            n_pl[k].nrm[i] = '0;
                        end else if (r_pl[k-1].neg[i]) begin
                            n_pl[k].nrm[i] = 18'(-nv);
                        end else begin
                            n_pl[k].nrm[i] = nv;
                        end
                    end
                end else if (k == ST_PRD) begin
                    for (int i = 0; i < 3; i++) begin
                        n_pl[k].prd[i] = 42'($signed(r_pl[k-1].vel[i])
                                         * $signed(r_pl[k-1].nrm[i]));
                    end
                end else if (k == ST_DOT) begin
                    n_pl[k].dot = 44'($signed(r_pl[k-1].prd[0]))
                                + 44'($signed(r_pl[k-1].prd[1]))
                                + 44'($signed(r_pl[k-1].prd[2]));
                end else if (k == ST_REF) begin
                    for (int i = 0; i < 3; i++) begin
                        n_pl[k].tp[i] = 62'($signed(r_pl[k-1].dot)
                                        * $signed(r_pl[k-1].nrm[i]));
                    end
                end else if (k == ST_BNC) begin
                    for (int i = 0; i < 3; i++) begin
                        // Twice the product, rounded half up to Q.8.
                        rq = $signed({r_pl[k-1].tp[i], 1'b0}) + 63'sd2147483648;
                        q  = 34'($signed(r_pl[k-1].vel[i])) - 34'(rq >>> 32);
                        n_pl[k].bnc[i] = f_sat24(q);
                    end
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = 34'($signed(r_pl[k-1].oth[i])) + 34'($signed(r_pl[k-1].bnc[i]));
                        if (r_pl[k-1].hit) begin
                            n_pl[k].nw[i] = f_sat24(q);
                        end else begin
                            n_pl[k].nw[i]  = '0;
                            n_pl[k].bnc[i] = '0;
                        end
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= (k == 0) ? i_s_tvalid : r_v[(k == 0) ? 0 : k - 1];
            end
            if (en[k]) begin
                r_pl[k] <= n_pl[k];
            end
        end
    end

    assign o_m_tvalid = r_v[N_STAGES-1];
    assign o_m_tuser  = r_pl[N_STAGES-1].hit;
    assign o_m_tdata  = {r_pl[N_STAGES-1].nw[2], r_pl[N_STAGES-1].nw[1],
                         r_pl[N_STAGES-1].nw[0], r_pl[N_STAGES-1].bnc[2],
                         r_pl[N_STAGES-1].bnc[1], r_pl[N_STAGES-1].bnc[0]};

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("result without hit carries non-zero data");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled while the output can move");

    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_m_tvalid)
        else $error("output valid straight after reset");

endmodule

>>> tb/sv/sphere_collision_bounce_test.sv
`timescale 1ns / 1ps
module sphere_collision_bounce_test;
    import scb_pkg::*;

    typedef struct {
        logic signed [23:0] own [3];
        logic [19:0]        own_r;
        logic signed [23:0] oth [3];
        logic [19:0]        oth_r;
        logic signed [23:0] vel [3];
    } pair_t;

    typedef struct {
        logic        hit;
        logic [23:0] bnc [3];
        logic [23:0] nw [3];
    } bounce_t;

    localparam int MAX_CYCLES = 400000;
    localparam longint S24_MAX = 8388607;
    localparam longint S24_MIN = -8388608;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [255:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [143:0] o_m_tdata;
    logic         o_m_tuser;

    bounce_t expected_q [$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      sending_done = 0;

    sphere_collision_bounce i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint clamp24(longint v);
        if (v > S24_MAX) return S24_MAX;
        if (v < S24_MIN) return S24_MIN;
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic bounce_t reflect(pair_t p);
        bounce_t res;
        longint d [3];
        longint n [3];
        longint unsigned dd = 0;
        longint unsigned rs;
        longint dot = 0;
        longint len, t, q, b;
        res.hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'(p.own[i]) - longint'(p.oth[i]);
            dd += longint'(d[i] * d[i]);
            res.bnc[i] = '0;
            res.nw[i] = '0;
        end
        rs = longint'(p.own_r) + longint'(p.oth_r);
        if (!(rs * rs > dd)) return res;
        res.hit = 1'b1;
        if (dd == 0) begin
            for (int i = 0; i < 3; i++) n[i] = 0;
        end else begin
            len = root_floor(dd << 14);
            for (int i = 0; i < 3; i++) begin
                t = (d[i] * 64'sd8388608) / len;
                if (t > 65536) t = 65536;
                if (t < -65536) t = -65536;
                n[i] = t;
            end
        end
        for (int i = 0; i < 3; i++) dot += longint'(p.vel[i]) * n[i];
        for (int i = 0; i < 3; i++) begin
            // Round half up to Q.8 with an arithmetic shift, which floors.
            q = (2 * dot * n[i] + (64'sd1 << 31)) >>> 32;
            b = clamp24(longint'(p.vel[i]) - q);
            res.bnc[i] = b[23:0];
            t = clamp24(longint'(p.oth[i]) + b);
            res.nw[i] = t[23:0];
        end
        return res;
    endfunction

    function automatic logic [255:0] pack_pair(pair_t p);
        logic [255:0] v = '0;
        v[71:0]    = {p.own[2], p.own[1], p.own[0]};
        v[91:72]   = p.own_r;
        v[163:92]  = {p.oth[2], p.oth[1], p.oth[0]};
        v[183:164] = p.oth_r;
        v[255:184] = {p.vel[2], p.vel[1], p.vel[0]};
        return v;
    endfunction

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom);
            1: return 24'($signed(14'($urandom)));
            default: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF - 24'($urandom_range(0, 3))
                                                        : 24'h800000 + 24'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int m = $urandom_range(0, 9);
        int cm = (m < 6) ? 1 : (m < 8 ? 0 : 2);
        for (int i = 0; i < 3; i++) begin
            p.own[i] = rand_coord(cm);
            // Mostly close neighbours so that most pairs hit.
            p.oth[i] = (m < 7) ? p.own[i] + 24'($signed(12'($urandom))) : rand_coord(cm);
            p.vel[i] = rand_coord($urandom_range(0, 2));
        end
        if ($urandom_range(0, 15) == 0) p.oth = p.own;
        p.own_r = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4095));
        p.oth_r = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 4095));
        return p;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_pair(pair_t p);
        int idle = $urandom_range(0, 9);
        if (idle > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_s_tdata  <= pack_pair(p);
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        expected_q.push_back(reflect(p));
        @(negedge i_clk);
    endtask

    function automatic pair_t make_pair(longint o, longint r1, longint t, longint r2, longint v);
        pair_t p;
        for (int i = 0; i < 3; i++) begin
            p.own[i] = 24'(o);
            p.oth[i] = 24'(t);
            p.vel[i] = 24'(v);
        end
        p.own_r = 20'(r1);
        p.oth_r = 20'(r2);
        return p;
    endfunction

    // Directed rows: fixed result only where it is obvious, else the predictor decides.
    task automatic run_directed();
        pair_t rows [$];
        pair_t p;
        rows.push_back(make_pair(0, 0, 0, 0, 100));                   // zero radii: no hit
        rows.push_back(make_pair(0, 256, 0, 0, 1000));                // coincident: bounce = v
        rows.push_back(make_pair(S24_MAX, 1048575, S24_MAX, 1048575, S24_MAX));
        rows.push_back(make_pair(S24_MIN, 1048575, S24_MIN, 1048575, S24_MIN));
        rows.push_back(make_pair(S24_MAX, 1048575, S24_MIN, 1048575, 5)); // far apart
        rows.push_back(make_pair(1000, 200, 0, 0, 256));              // too far apart: no hit
        rows.push_back(make_pair(1000, 1000, 0, 1000, 256));
        rows.push_back(make_pair(0, 1048575, 1000, 1048575, S24_MAX));
        rows.push_back(make_pair(0, 1048575, -1000, 1048575, S24_MIN));
        rows.push_back(make_pair(S24_MAX, 1048575, S24_MAX - 300, 1048575, S24_MIN));
        rows.push_back(make_pair(-1, 1, 0, 1, -1));
        p = make_pair(0, 4096, 0, 4096, 0);
        p.oth[0] = 24'sd512; p.vel[0] = -24'sd768; p.vel[1] = 24'sd33;
        rows.push_back(p);
        p = make_pair(200, 500, 0, 500, S24_MAX);
        p.vel[2] = -24'sd77; p.oth[1] = 24'sd100;
        rows.push_back(p);
        foreach (rows[k]) begin
            send_pair(rows[k]);
            if (k == 0 || k == 5) begin
                // Plain zero result expected here, typed in directly.
                expected_q[$].hit = 1'b0;
            end else if (k == 1) begin
                expected_q[$].hit = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    expected_q[$].bnc[i] = 24'd1000;
                    expected_q[$].nw[i]  = 24'd1000;
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        repeat (800) send_pair(random_pair());
        i_s_tvalid <= 1'b0;
        sending_done = 1;
    end

    // Result side: random stalls, plus one long hold-off so the pipeline backs up.
    initial begin
        int gap;
        int rx_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            if (rx_cycles >= 2000 && rx_cycles < 2400) begin
                i_m_tready <= 1'b0;
                @(negedge i_clk);
                rx_cycles++;
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
                if (gap == 0 || $urandom_range(0, 9) < 6) begin
                    i_m_tready <= 1'b1;
                    @(negedge i_clk);
                    rx_cycles++;
                end else begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    rx_cycles += gap;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        bounce_t e;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h hit %b", o_m_tdata, o_m_tuser);
            end else begin
                e = expected_q.pop_front();
                if (o_m_tuser !== e.hit
                    || o_m_tdata !== {e.nw[2], e.nw[1], e.nw[0], e.bnc[2], e.bnc[1], e.bnc[0]}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected hit %b %h, got hit %b %h", e.hit,
                                 {e.nw[2], e.nw[1], e.nw[0], e.bnc[2], e.bnc[1], e.bnc[0]},
                                 o_m_tuser, o_m_tdata);
                end
            end
        end
    end

    initial begin
        wait (sending_done && expected_q.size() == 0 || cycles >= MAX_CYCLES);
        if (cycles < MAX_CYCLES) begin
            repeat (80) @(posedge i_clk);
            if (mismatches == 0 && expected_q.size() == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
        end else begin
            $display("Timed out with %0d results outstanding", expected_q.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sphere_collision_bounce.f
rtl/scb_pkg.sv
rtl/sphere_collision_bounce.sv
tb/sv/sphere_collision_bounce_test.sv
